[hw/rtl/cyc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyc_pkg
// Shared types and constants for the coincidence yield counter.
// ----------------------------------------------------------------------------
package cyc_pkg;

  localparam int unsigned TableDepthDef = 4096;
  localparam int unsigned MaxWindowsDef = 8;
  localparam logic [15:0] TotalChanLimit = 16'd64000;

  localparam int unsigned KeyW     = 40;
  localparam int unsigned PayloadW = 56;

  typedef enum logic [2:0] {
    MODE_LOAD_ROW = 3'd0,
    MODE_LOAD_WIN = 3'd1,
    MODE_EVENT    = 3'd2,
    MODE_REPORT   = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ROWS  = 2'd0,
    KIND_WIN   = 2'd1,
    KIND_TOTAL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_SR_LOW   = 3'd0,
    REG_SR_HIGH  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_RADIUS   = 3'd4,
    REG_WIN_USED = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,     // issue memory read at mid
    ST_CMP,       // compare key
    ST_QUAL1,     // qualify stage 1: deltas and bounds
    ST_QUAL2,     // qualify stage 2: squares
    ST_QUAL3,     // qualify stage 3: sum and compare
    ST_BUMP,      // update counters
    ST_SCAN,      // report: walk table
    ST_SCAN_DRAIN,
    ST_EMIT
  } state_t;

endpackage

[hw/rtl/coincidence_yield_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincidence_yield_counter_top
// Row table lookup, window counting and report generation.
// ----------------------------------------------------------------------------
// One item is handled at a time. Row and window loads complete on acceptance. A
// TOF event binary-searches the row table held in one synchronous memory: the
// accept step, then at most ceil(log2(rows+1)) probes, each a read then a
// compare, then three qualification stages and one counter update. A report
// walks every stored row through the same pipeline, then emits 2 +
// min(windows_used, MAX_WINDOWS) transfers, one per cycle when not stalled.
// Clear all completes on acceptance.
module coincidence_yield_counter_top #(
  parameter int unsigned TABLE_DEPTH = cyc_pkg::TableDepthDef,
  parameter int unsigned MAX_WINDOWS = cyc_pkg::MaxWindowsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_file_number,
  input  logic [23:0] in_frame_number,
  input  logic [15:0] in_tof_channel,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic signed [31:0] in_ratio,
  input  logic [2:0]  in_window_slot,
  input  logic [15:0] in_window_low,
  input  logic [15:0] in_window_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_window_index,
  output logic [31:0] out_count,
  output logic        out_overflow,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NC  = MAX_WINDOWS + 1;
  localparam int unsigned CIW = $clog2(NC);
  localparam int unsigned WIW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam logic signed [CW:0] ONE = 1;

  // ---------------- configuration ----------------
  logic signed [31:0] sr_low_r, sr_high_r;
  logic [11:0] center_x_r, center_y_r;
  logic [12:0] radius_r;
  logic [3:0]  win_used_r;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_low_r   <= '0;
      sr_high_r  <= '0;
      center_x_r <= 12'd236;
      center_y_r <= 12'd872;
      radius_r   <= 13'd5000;
      win_used_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        cyc_pkg::REG_SR_LOW:   sr_low_r   <= cfg_pwdata;
        cyc_pkg::REG_SR_HIGH:  sr_high_r  <= cfg_pwdata;
        cyc_pkg::REG_CENTER_X: center_x_r <= cfg_pwdata[11:0];
        cyc_pkg::REG_CENTER_Y: center_y_r <= cfg_pwdata[11:0];
        cyc_pkg::REG_RADIUS:   radius_r   <= cfg_pwdata[12:0];
        cyc_pkg::REG_WIN_USED: win_used_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cyc_pkg::REG_SR_LOW:   cfg_prdata = sr_low_r;
      cyc_pkg::REG_SR_HIGH:  cfg_prdata = sr_high_r;
      cyc_pkg::REG_CENTER_X: cfg_prdata = {20'd0, center_x_r};
      cyc_pkg::REG_CENTER_Y: cfg_prdata = {20'd0, center_y_r};
      cyc_pkg::REG_RADIUS:   cfg_prdata = {19'd0, radius_r};
      cyc_pkg::REG_WIN_USED: cfg_prdata = {28'd0, win_used_r};
      default:               cfg_prdata = '0;
    endcase
  end

  logic [3:0] nw;
  assign nw = (win_used_r > 4'(MAX_WINDOWS)) ? 4'(MAX_WINDOWS) : win_used_r;

  // ---------------- row memory ----------------
  logic [cyc_pkg::KeyW+cyc_pkg::PayloadW-1:0] row_mem [TABLE_DEPTH];
  logic [cyc_pkg::KeyW+cyc_pkg::PayloadW-1:0] rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [cyc_pkg::KeyW+cyc_pkg::PayloadW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) row_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= row_mem[mem_raddr];
  end

  logic [cyc_pkg::KeyW-1:0]     rd_key;
  logic [cyc_pkg::PayloadW-1:0] rd_pay;
  assign rd_key = rd_data_r[cyc_pkg::KeyW+cyc_pkg::PayloadW-1:cyc_pkg::PayloadW];
  assign rd_pay = rd_data_r[cyc_pkg::PayloadW-1:0];

  // ---------------- windows, counters ----------------
  logic [15:0] win_lo_r [MAX_WINDOWS];
  logic [15:0] win_hi_r [MAX_WINDOWS];
  logic [31:0] cnt_r [NC];

  // ---------------- control ----------------
  cyc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] row_count_r;
  logic          ovf_r;
  logic signed [CW:0] lo_r, hi_r;
  logic [AW-1:0] mid_r;
  logic [cyc_pkg::KeyW-1:0] key_r;
  logic [15:0]   chn_r;
  logic          is_scan_r;
  logic [CW-1:0] scan_i_r;
  logic [2:0]    drain_r;
  logic [31:0]   q_r;
  logic [3:0]    emit_i_r;
  // qualification pipeline
  logic          p1_v_r, p2_v_r, p3_v_r;
  logic          p1_r_ok_r, p2_r_ok_r;
  logic signed [12:0] dx_r, dy_r;
  logic [25:0]   rr_r, rr2_r, dx2_r, dy2_r;
  logic          qual_r;

  logic acc_in, acc_out;
  assign acc_in  = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;
  assign in_stall = (state_r != cyc_pkg::ST_IDLE);

  logic signed [CW:0] mid_calc;
  assign mid_calc = lo_r + ((hi_r - lo_r) >>> 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cyc_pkg::ST_IDLE: begin
        if (acc_in && in_mode == cyc_pkg::MODE_EVENT) state_nxt = cyc_pkg::ST_PROBE;
        else if (acc_in && in_mode == cyc_pkg::MODE_REPORT) state_nxt = cyc_pkg::ST_SCAN;
      end
      cyc_pkg::ST_PROBE: state_nxt = (lo_r <= hi_r) ? cyc_pkg::ST_CMP : cyc_pkg::ST_IDLE;
      cyc_pkg::ST_CMP:
        state_nxt = (rd_key == key_r) ? cyc_pkg::ST_QUAL1 : cyc_pkg::ST_PROBE;
      cyc_pkg::ST_QUAL1: state_nxt = cyc_pkg::ST_QUAL2;
      cyc_pkg::ST_QUAL2: state_nxt = cyc_pkg::ST_QUAL3;
      cyc_pkg::ST_QUAL3: state_nxt = cyc_pkg::ST_BUMP;
      cyc_pkg::ST_BUMP:  state_nxt = cyc_pkg::ST_IDLE;
      cyc_pkg::ST_SCAN:
        if (scan_i_r >= row_count_r) state_nxt = cyc_pkg::ST_SCAN_DRAIN;
      cyc_pkg::ST_SCAN_DRAIN: if (drain_r == 3'd5) state_nxt = cyc_pkg::ST_EMIT;
      cyc_pkg::ST_EMIT:
        if (acc_out && emit_i_r == nw + 4'd1) state_nxt = cyc_pkg::ST_IDLE;
      default: state_nxt = cyc_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = acc_in && in_mode == cyc_pkg::MODE_LOAD_ROW
                && row_count_r < CW'(TABLE_DEPTH);
    mem_waddr = row_count_r[AW-1:0];
    mem_wdata = {in_file_number, in_frame_number, in_ratio, in_pos_y, in_pos_x};
    mem_re    = 1'b0;
    mem_raddr = mid_calc[AW-1:0];
    if (state_r == cyc_pkg::ST_PROBE) begin
      mem_re = (lo_r <= hi_r);
    end else if (state_r == cyc_pkg::ST_SCAN) begin
      mem_re    = (scan_i_r < row_count_r);
      mem_raddr = scan_i_r[AW-1:0];
    end
  end

  // qualification pipeline inputs: row read data valid in the cycle after the read
  logic p0_v;
  logic p0_v_r;
  assign p0_v = (state_r == cyc_pkg::ST_CMP && rd_key == key_r) || p0_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p0_v_r <= (state_r == cyc_pkg::ST_SCAN) && (scan_i_r < row_count_r);
      p1_v_r <= p0_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r      <= $signed({1'b0, rd_pay[11:0]}) - $signed({1'b0, center_x_r});
    dy_r      <= $signed({1'b0, rd_pay[23:12]}) - $signed({1'b0, center_y_r});
    p1_r_ok_r <= ($signed(rd_pay[55:24]) >= sr_low_r)
                 && ($signed(rd_pay[55:24]) < sr_high_r);
    rr_r      <= radius_r * radius_r;
    dx2_r     <= 26'($signed(dx_r) * $signed(dx_r));
    dy2_r     <= 26'($signed(dy_r) * $signed(dy_r));
    rr2_r     <= rr_r;
    p2_r_ok_r <= p1_r_ok_r;
    qual_r    <= p2_r_ok_r && ({1'b0, dx2_r} + {1'b0, dy2_r} < {1'b0, rr2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cyc_pkg::ST_IDLE;
      row_count_r <= '0;
      ovf_r       <= 1'b0;
      for (int i = 0; i < NC; i++) cnt_r[i] <= '0;
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        win_lo_r[i] <= '0;
        win_hi_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (acc_in) begin
        unique case (in_mode)
          cyc_pkg::MODE_LOAD_ROW: begin
            if (row_count_r < CW'(TABLE_DEPTH)) row_count_r <= row_count_r + 1'b1;
            else ovf_r <= 1'b1;
          end
          cyc_pkg::MODE_LOAD_WIN: begin
            if (32'(in_window_slot) < MAX_WINDOWS) begin
              win_lo_r[in_window_slot[WIW-1:0]] <= in_window_low;
              win_hi_r[in_window_slot[WIW-1:0]] <= in_window_high;
            end
          end
          cyc_pkg::MODE_CLEAR: begin
            row_count_r <= '0;
            ovf_r       <= 1'b0;
            for (int i = 0; i < NC; i++) cnt_r[i] <= '0;
            for (int i = 0; i < MAX_WINDOWS; i++) begin
              win_lo_r[i] <= '0;
              win_hi_r[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state_r == cyc_pkg::ST_BUMP && qual_r) begin
        for (int i = 0; i < MAX_WINDOWS; i++)
          if (4'(i) < nw && win_lo_r[i] <= chn_r && chn_r < win_hi_r[i]
              && cnt_r[i] != '1)
            cnt_r[i] <= cnt_r[i] + 1'b1;
        if (chn_r < cyc_pkg::TotalChanLimit && cnt_r[MAX_WINDOWS] != '1)
          cnt_r[MAX_WINDOWS] <= cnt_r[MAX_WINDOWS] + 1'b1;
      end
      if (state_r == cyc_pkg::ST_EMIT && state_nxt == cyc_pkg::ST_IDLE)
        for (int i = 0; i < NC; i++) cnt_r[i] <= '0;
    end
  end

  // search and scan datapath registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      key_r    <= {in_file_number, in_frame_number};
      chn_r    <= in_tof_channel;
      lo_r     <= '0;
      hi_r     <= $signed({1'b0, row_count_r}) - ONE;
      scan_i_r <= '0;
      drain_r  <= '0;
      q_r      <= '0;
      emit_i_r <= '0;
      is_scan_r <= (in_mode == cyc_pkg::MODE_REPORT);
    end else begin
      if (state_r == cyc_pkg::ST_PROBE) mid_r <= mid_calc[AW-1:0];
      if (state_r == cyc_pkg::ST_CMP && rd_key != key_r) begin
        if (rd_key < key_r) lo_r <= $signed({{(CW+1-AW){1'b0}}, mid_r}) + ONE;
        else                hi_r <= $signed({{(CW+1-AW){1'b0}}, mid_r}) - ONE;
      end
      if (state_r == cyc_pkg::ST_SCAN && scan_i_r < row_count_r)
        scan_i_r <= scan_i_r + 1'b1;
      if (state_r == cyc_pkg::ST_SCAN_DRAIN) drain_r <= drain_r + 1'b1;
      if (is_scan_r && p3_v_r && qual_r && q_r != '1) q_r <= q_r + 1'b1;
      if (acc_out) emit_i_r <= emit_i_r + 1'b1;
    end
  end

  // ---------------- result channel ----------------
  logic [CIW-1:0] emit_w;
  assign emit_w = CIW'(emit_i_r - 4'd1);

  always_comb begin
    out_valid        = (state_r == cyc_pkg::ST_EMIT);
    out_overflow     = ovf_r;
    out_last         = (emit_i_r == nw + 4'd1);
    out_window_index = '0;
    if (emit_i_r == 4'd0) begin
      out_kind  = cyc_pkg::KIND_ROWS;
      out_count = q_r;
    end else if (out_last) begin
      out_kind  = cyc_pkg::KIND_TOTAL;
      out_count = cnt_r[MAX_WINDOWS];
    end else begin
      out_kind         = cyc_pkg::KIND_WIN;
      out_window_index = emit_i_r - 4'd1;
      out_count        = cnt_r[emit_w];
    end
  end

endmodule

[hw/rtl/cyc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyc_checker
// Port-level checks for the coincidence yield counter.
// ----------------------------------------------------------------------------
module cyc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic       out_last,
  input logic [3:0] out_window_index,
  input logic       cfg_pready
);

  // no new item is taken while results are pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted during report");

  // the final transfer of a report is the total
  a_last_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_kind == cyc_pkg::KIND_TOTAL)
    else $error("last result is not total");

  // window index only on window counts
  a_widx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != cyc_pkg::KIND_WIN) |-> out_window_index == 4'd0)
    else $error("window index on non-window result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_kind))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind coincidence_yield_counter_top cyc_checker u_cyc_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_kind,
  .out_last, .out_window_index, .cfg_pready
);

[test/tb_coincidence_yield_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coincidence_yield_counter_top
// Self-checking bench for the coincidence yield counter. A queue of commands
// (row, window, event, report and clear transfers, register writes and
// drain points) feeds a clocked driver. A scoreboard model tracks the row
// table, windows and counters and predicts every report transfer, which a
// clocked monitor compares field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_coincidence_yield_counter_top;

  localparam int unsigned DEPTH    = cyc_pkg::TableDepthDef;
  localparam int unsigned NWIN     = cyc_pkg::MaxWindowsDef;
  localparam int unsigned SETTLE   = 48;      // > worst event latency
  localparam int unsigned LIMIT    = 600000;
  localparam int unsigned N_RANDOM = 200;
  localparam int unsigned N_LONG   = 32;

  typedef enum logic [1:0] {CMD_ITEM, CMD_CFG, CMD_DRAIN} cmd_kind_t;

  typedef struct {
    cmd_kind_t   kind;
    bit          nogap;
    logic [2:0]  mode;
    logic [15:0] file_no;
    logic [23:0] frame_no;
    logic [15:0] chan;
    logic [11:0] px;
    logic [11:0] py;
    logic [31:0] ratio;
    logic [2:0]  slot;
    logic [15:0] wlo;
    logic [15:0] whi;
    cyc_pkg::reg_idx_t ridx;
    logic [31:0] rval;
  } cmd_t;

  typedef struct {
    cyc_pkg::kind_t kind;
    logic [3:0]  widx;
    logic [31:0] count;
    logic        ovf;
    logic        last;
  } yield_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = '0;
  logic [15:0] in_file_number = '0;
  logic [23:0] in_frame_number = '0;
  logic [15:0] in_tof_channel = '0;
  logic [11:0] in_pos_x = '0;
  logic [11:0] in_pos_y = '0;
  logic signed [31:0] in_ratio = '0;
  logic [2:0]  in_window_slot = '0;
  logic [15:0] in_window_low = '0;
  logic [15:0] in_window_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_window_index;
  logic [31:0] out_count;
  logic        out_overflow;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  coincidence_yield_counter_top u_top (.*);

  always #6 clk = ~clk;

  // model state
  logic [39:0]        tbl_key   [DEPTH];
  logic [11:0]        tbl_x     [DEPTH];
  logic [11:0]        tbl_y     [DEPTH];
  logic signed [31:0] tbl_ratio [DEPTH];
  int unsigned        tbl_rows = 0;
  logic [15:0]        win_lo [NWIN];
  logic [15:0]        win_hi [NWIN];
  logic [31:0]        hit_ctr [NWIN+1];
  logic               tbl_ovf = 1'b0;
  logic signed [31:0] g_sr_lo = 0;
  logic signed [31:0] g_sr_hi = 0;
  logic [11:0]        g_cx = 12'd236;
  logic [11:0]        g_cy = 12'd872;
  logic [12:0]        g_rad = 13'd5000;
  logic [3:0]         g_wu = 4'd0;

  cmd_t   cmd_q [$];
  yield_t yield_q [$];
  cmd_t   cur_item;
  cmd_t   cur_cfg;
  int unsigned gap_cnt = 0;
  int unsigned quiet_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned n_items = 0;

  // stimulus-side view of the circle, used to place points near it
  int st_cx = 236;
  int st_cy = 872;
  int st_rad = 5000;

  initial begin
    for (int i = 0; i <= NWIN; i++) hit_ctr[i] = '0;
    for (int i = 0; i < NWIN; i++) begin
      win_lo[i] = '0;
      win_hi[i] = '0;
    end
  end

  // long calm stretches with no idling on either side
  function automatic int unsigned draw_wait();
    if (cyc_cnt % 3000 < 700) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic bit row_in_gate(logic [11:0] x, logic [11:0] y,
                                     logic signed [31:0] r);
    longint dx, dy, rr;
    dx = longint'(x) - longint'(g_cx);
    dy = longint'(y) - longint'(g_cy);
    rr = longint'(g_rad) * longint'(g_rad);
    return (r >= g_sr_lo) && (r < g_sr_hi) && (dx * dx + dy * dy < rr);
  endfunction

  function automatic void bump_ctr(int i);
    if (hit_ctr[i] != 32'hFFFF_FFFF) hit_ctr[i] = hit_ctr[i] + 1;
  endfunction

  task automatic predict_item(cmd_t c);
    logic [39:0] key;
    int lo, hi, mid, nw;
    bit hit;
    logic [31:0] q;
    yield_t y;
    key = {c.file_no, c.frame_no};
    nw  = (g_wu > NWIN) ? NWIN : g_wu;
    case (c.mode)
      cyc_pkg::MODE_LOAD_ROW: begin
        if (tbl_rows < DEPTH) begin
          tbl_key[tbl_rows]   = key;
          tbl_x[tbl_rows]     = c.px;
          tbl_y[tbl_rows]     = c.py;
          tbl_ratio[tbl_rows] = c.ratio;
          tbl_rows++;
        end else begin
          tbl_ovf = 1'b1;
        end
      end
      cyc_pkg::MODE_LOAD_WIN: begin
        if (c.slot < NWIN) begin
          win_lo[c.slot] = c.wlo;
          win_hi[c.slot] = c.whi;
        end
      end
      cyc_pkg::MODE_EVENT: begin
        lo = 0;
        hi = int'(tbl_rows) - 1;
        hit = 1'b0;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (tbl_key[mid] == key) begin
            hit = row_in_gate(tbl_x[mid], tbl_y[mid], tbl_ratio[mid]);
            break;
          end else if (tbl_key[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (hit) begin
          for (int i = 0; i < nw; i++)
            if (win_lo[i] <= c.chan && c.chan < win_hi[i]) bump_ctr(i);
          if (c.chan < cyc_pkg::TotalChanLimit) bump_ctr(NWIN);
        end
      end
      cyc_pkg::MODE_REPORT: begin
        q = '0;
        for (int i = 0; i < tbl_rows; i++)
          if (row_in_gate(tbl_x[i], tbl_y[i], tbl_ratio[i]) && q != 32'hFFFF_FFFF)
            q = q + 1;
        y = '{kind: cyc_pkg::KIND_ROWS, widx: '0, count: q, ovf: tbl_ovf, last: 1'b0};
        yield_q.insert(yield_q.size(), y);
        for (int i = 0; i < nw; i++) begin
          y = '{kind: cyc_pkg::KIND_WIN, widx: 4'(i), count: hit_ctr[i], ovf: tbl_ovf,
                last: 1'b0};
          yield_q.insert(yield_q.size(), y);
        end
        y = '{kind: cyc_pkg::KIND_TOTAL, widx: '0, count: hit_ctr[NWIN], ovf: tbl_ovf,
              last: 1'b1};
        yield_q.insert(yield_q.size(), y);
        for (int i = 0; i <= NWIN; i++) hit_ctr[i] = '0;
      end
      cyc_pkg::MODE_CLEAR: begin
        tbl_rows = 0;
        tbl_ovf  = 1'b0;
        for (int i = 0; i <= NWIN; i++) hit_ctr[i] = '0;
        for (int i = 0; i < NWIN; i++) begin
          win_lo[i] = '0;
          win_hi[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic void apply_reg(cyc_pkg::reg_idx_t r, logic [31:0] v);
    case (r)
      cyc_pkg::REG_SR_LOW:   g_sr_lo = v;
      cyc_pkg::REG_SR_HIGH:  g_sr_hi = v;
      cyc_pkg::REG_CENTER_X: g_cx = v[11:0];
      cyc_pkg::REG_CENTER_Y: g_cy = v[11:0];
      cyc_pkg::REG_RADIUS:   g_rad = v[12:0];
      cyc_pkg::REG_WIN_USED: g_wu = v[3:0];
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin : driver
    cmd_t c;
    logic hold, launch;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      gap_cnt     <= 0;
      quiet_cnt   <= 0;
    end else begin
      hold   = in_valid;
      launch = 1'b0;
      if (in_valid && !in_stall) begin
        predict_item(cur_item);
        hold = 1'b0;
      end
      if (yield_q.size() == 0 && !hold && !cfg_psel) quiet_cnt <= quiet_cnt + 1;
      else quiet_cnt <= 0;
      if (cfg_psel) begin
        if (!cfg_penable) begin
          cfg_penable <= 1'b1;
        end else if (cfg_pready) begin
          apply_reg(cur_cfg.ridx, cur_cfg.rval);
          cfg_psel    <= 1'b0;
          cfg_penable <= 1'b0;
        end
      end else if (!hold) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (cmd_q.size() != 0) begin
          c = cmd_q[0];
          case (c.kind)
            CMD_ITEM: begin
              void'(cmd_q.pop_front());
              in_mode         <= c.mode;
              in_file_number  <= c.file_no;
              in_frame_number <= c.frame_no;
              in_tof_channel  <= c.chan;
              in_pos_x        <= c.px;
              in_pos_y        <= c.py;
              in_ratio        <= c.ratio;
              in_window_slot  <= c.slot;
              in_window_low   <= c.wlo;
              in_window_high  <= c.whi;
              cur_item        <= c;
              launch = 1'b1;
              gap_cnt <= c.nogap ? 0 : draw_wait();
            end
            CMD_CFG: begin
              if (quiet_cnt >= SETTLE) begin
                void'(cmd_q.pop_front());
                cfg_psel   <= 1'b1;
                cfg_pwrite <= 1'b1;
                cfg_paddr  <= {c.ridx, 2'b00};
                cfg_pwdata <= c.rval;
                cur_cfg    <= c;
              end
            end
            default: begin
              if (yield_q.size() == 0) void'(cmd_q.pop_front());
            end
          endcase
        end
      end
      in_valid <= hold | launch;
    end
  end

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, what, exp_v, act_v);
  endtask

  // monitor
  always @(posedge clk) begin : monitor
    yield_t e;
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else begin
      n = stall_cnt;
      if (out_valid && !out_stall) begin
        if (yield_q.size() == 0) begin
          note_mismatch("unexpected transfer, count", 32'h0, out_count);
        end else begin
          e = yield_q.pop_front();
          if (out_kind != e.kind) note_mismatch("kind", e.kind, out_kind);
          if (out_window_index != e.widx) note_mismatch("window_index", e.widx, out_window_index);
          if (out_count != e.count) note_mismatch("count", e.count, out_count);
          if (out_overflow != e.ovf) note_mismatch("overflow", e.ovf, out_overflow);
          if (out_last != e.last) note_mismatch("last", e.last, out_last);
        end
        n = draw_wait();
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        stall_cnt <= n - 1;
      end else begin
        out_stall <= 1'b0;
        stall_cnt <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic cmd_t base_item(logic [2:0] m);
    cmd_t c;
    c.kind = CMD_ITEM;
    c.nogap = 1'b0;
    c.mode = m;
    c.file_no = 16'($urandom);
    c.frame_no = 24'($urandom);
    c.chan = 16'($urandom);
    c.px = 12'($urandom);
    c.py = 12'($urandom);
    c.ratio = $urandom;
    c.slot = 3'($urandom);
    c.wlo = 16'($urandom);
    c.whi = 16'($urandom);
    c.ridx = cyc_pkg::REG_SR_LOW;
    c.rval = '0;
    return c;
  endfunction

  function automatic void push_item(cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
    n_items++;
  endfunction

  function automatic void add_op(logic [2:0] m);
    push_item(base_item(m));
  endfunction

  function automatic void add_row(logic [39:0] k, logic [11:0] x, logic [11:0] y,
                                  logic [31:0] r, bit ng);
    cmd_t c;
    c = base_item(cyc_pkg::MODE_LOAD_ROW);
    {c.file_no, c.frame_no} = k;
    c.px = x;
    c.py = y;
    c.ratio = r;
    c.nogap = ng;
    push_item(c);
  endfunction

  function automatic void add_event(logic [39:0] k, logic [15:0] ch);
    cmd_t c;
    c = base_item(cyc_pkg::MODE_EVENT);
    {c.file_no, c.frame_no} = k;
    c.chan = ch;
    push_item(c);
  endfunction

  function automatic void add_win(logic [2:0] s, logic [15:0] lo, logic [15:0] hi);
    cmd_t c;
    c = base_item(cyc_pkg::MODE_LOAD_WIN);
    c.slot = s;
    c.wlo = lo;
    c.whi = hi;
    push_item(c);
  endfunction

  function automatic void add_cfg(cyc_pkg::reg_idx_t r, logic [31:0] v);
    cmd_t c;
    c = base_item(cyc_pkg::MODE_CLEAR);
    c.kind = CMD_CFG;
    c.ridx = r;
    c.rval = v;
    cmd_q.insert(cmd_q.size(), c);
    case (r)
      cyc_pkg::REG_CENTER_X: st_cx = v[11:0];
      cyc_pkg::REG_CENTER_Y: st_cy = v[11:0];
      cyc_pkg::REG_RADIUS:   st_rad = v[12:0];
      default: ;
    endcase
  endfunction

  function automatic void add_drain();
    cmd_t c;
    c = base_item(cyc_pkg::MODE_CLEAR);
    c.kind = CMD_DRAIN;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic logic [11:0] near(int ctr);
    int v;
    int span;
    span = (st_rad < 1500) ? st_rad + 20 : 1500;
    if ($urandom_range(0, 4) == 0) return 12'($urandom);
    v = ctr + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic logic [31:0] rand_ratio();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h60000) - 32'h30000;
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'($urandom_range(63990, 64010));
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic void add_rand_win(logic [2:0] s);
    int lo;
    lo = $urandom_range(0, 2500);
    case ($urandom_range(0, 7))
      0: add_win(s, 16'(lo), 16'($urandom_range(0, lo)));   // empty
      1: add_win(s, 16'd0, 16'hFFFF);
      2: add_win(s, 16'($urandom), 16'($urandom));
      default: add_win(s, 16'(lo), 16'(lo + $urandom_range(1, 1500)));
    endcase
  endfunction

  function automatic void rand_regs(bit all);
    if (all || $urandom_range(0, 1))
      add_cfg(cyc_pkg::REG_SR_LOW, ($urandom_range(0, 5) == 0) ? 32'h8000_0000
                                                : -$urandom_range(0, 32'h30000));
    if (all || $urandom_range(0, 1))
      case ($urandom_range(0, 5))
        0: add_cfg(cyc_pkg::REG_SR_HIGH, 32'h7FFF_FFFF);
        1: add_cfg(cyc_pkg::REG_SR_HIGH, 32'hFFFE_0000);
        default: add_cfg(cyc_pkg::REG_SR_HIGH, $urandom_range(0, 32'h30000));
      endcase
    if (all || $urandom_range(0, 1))
      add_cfg(cyc_pkg::REG_CENTER_X,
              ($urandom_range(0, 5) == 0) ? 32'(4095 * $urandom_range(0, 1))
                                          : $urandom_range(0, 4095));
    if (all || $urandom_range(0, 1))
      add_cfg(cyc_pkg::REG_CENTER_Y,
              ($urandom_range(0, 5) == 0) ? 32'(4095 * $urandom_range(0, 1))
                                          : $urandom_range(0, 4095));
    if (all || $urandom_range(0, 1))
      case ($urandom_range(0, 7))
        0: add_cfg(cyc_pkg::REG_RADIUS, 32'd0);
        1: add_cfg(cyc_pkg::REG_RADIUS, 32'd8191);
        default: add_cfg(cyc_pkg::REG_RADIUS, $urandom_range(200, 3000));
      endcase
    if (all || $urandom_range(0, 1))
      add_cfg(cyc_pkg::REG_WIN_USED, $urandom_range(0, 15));
  endfunction

  initial begin : stimulus
    logic [39:0] kq [$];
    logic [39:0] k;
    int seg, nr, ne, j;

    // directed: boundaries of the gate, both ends of the key space
    add_cfg(cyc_pkg::REG_SR_LOW, 32'hFFFF_0000);
    add_cfg(cyc_pkg::REG_SR_HIGH, 32'h0002_0000);
    add_cfg(cyc_pkg::REG_CENTER_X, 32'd2000);
    add_cfg(cyc_pkg::REG_CENTER_Y, 32'd2000);
    add_cfg(cyc_pkg::REG_RADIUS, 32'd1000);
    add_cfg(cyc_pkg::REG_WIN_USED, 32'd4);
    add_win(3'd0, 16'd0, 16'hFFFF);
    add_win(3'd1, 16'd100, 16'd200);
    add_win(3'd2, 16'd500, 16'd500);
    add_win(3'd3, 16'hFFFF, 16'd0);
    add_row({16'h0000, 24'h000000}, 12'd2000, 12'd2000, 32'h0, 1'b0);
    add_row({16'h0001, 24'h000010}, 12'd2999, 12'd2000, 32'hFFFF_0000, 1'b0);
    add_row({16'h0002, 24'hFFFFFF}, 12'd3000, 12'd2000, 32'h0, 1'b0);  // on circle
    add_row({16'h8000, 24'h000000}, 12'd2000, 12'd2000, 32'h0002_0000, 1'b0);
    add_row({16'hFFFF, 24'hFFFFFF}, 12'd2000, 12'd2500, 32'h0001_FFFF, 1'b0);
    add_event({16'h0000, 24'h000000}, 16'd0);
    add_event({16'h0000, 24'h000000}, 16'd150);
    add_event({16'hFFFF, 24'hFFFFFF}, 16'd63999);
    add_event({16'hFFFF, 24'hFFFFFF}, 16'd64000);
    add_event({16'h0001, 24'h000010}, 16'hFFFF);
    add_event({16'h0002, 24'hFFFFFF}, 16'd150);
    add_event({16'h0001, 24'h000011}, 16'd150);   // missing key
    for (int m = 1; m <= 3; m++) add_op(3'(cyc_pkg::MODE_CLEAR) + 3'(m));
    add_op(cyc_pkg::MODE_REPORT);
    add_op(cyc_pkg::MODE_CLEAR);
    add_op(cyc_pkg::MODE_REPORT);

    // random segments
    seg = 0;
    while (n_items < N_RANDOM) begin
      seg++;
      if (seg == 1 || $urandom_range(0, 2) == 0) rand_regs(seg == 1);
      add_op(cyc_pkg::MODE_CLEAR);
      for (int s = 0; s < NWIN; s++) add_rand_win(3'(s));
      nr = $urandom_range(1, 24);
      kq.delete();
      for (int i = 0; i < nr; i++) begin
        if ($urandom_range(0, 3) == 0) k = {16'($urandom), 24'($urandom)};
        else k = {16'($urandom_range(0, 3)), 24'($urandom_range(0, 200))};
        kq.insert(kq.size(), k);
      end
      kq.sort();
      if ($urandom_range(0, 5) == 0) begin
        j = $urandom_range(0, nr - 1);
        kq.insert(j, kq[j]);
      end
      if ($urandom_range(0, 5) == 0) kq.shuffle();
      foreach (kq[i]) add_row(kq[i], near(st_cx), near(st_cy), rand_ratio(), 1'b0);
      ne = $urandom_range(3, 20);
      for (int i = 0; i < ne; i++) begin
        case ($urandom_range(0, 19))
          0, 1: add_op(3'(cyc_pkg::MODE_CLEAR) + 3'($urandom_range(1, 3)));
          2, 3: add_rand_win(3'($urandom));
          4:    add_row({16'($urandom), 24'($urandom)}, near(st_cx), near(st_cy),
                        rand_ratio(), 1'b0);
          5, 6, 7: add_event({16'($urandom), 24'($urandom)}, rand_chan());
          default: add_event(kq[$urandom_range(0, kq.size() - 1)], rand_chan());
        endcase
      end
      add_op(cyc_pkg::MODE_REPORT);
      if ($urandom_range(0, 4) == 0) add_op(cyc_pkg::MODE_REPORT);
      if (seg == 3) add_drain();
    end

    // longer sorted table, back to back loads: first, middle and last row reachable
    add_cfg(cyc_pkg::REG_SR_LOW, 32'h8000_0000);
    add_cfg(cyc_pkg::REG_SR_HIGH, 32'h7FFF_FFFF);
    add_cfg(cyc_pkg::REG_CENTER_X, 32'd2048);
    add_cfg(cyc_pkg::REG_CENTER_Y, 32'd2048);
    add_cfg(cyc_pkg::REG_RADIUS, 32'd8191);
    add_cfg(cyc_pkg::REG_WIN_USED, 32'd8);
    add_op(cyc_pkg::MODE_CLEAR);
    for (int s = 0; s < NWIN; s++) add_rand_win(3'(s));
    for (int i = 0; i < N_LONG; i++)
      add_row(40'(i) * 40'd977 + 40'd5, 12'($urandom), 12'($urandom),
              (i % 8 == 7) ? 32'h7FFF_FFFF : $urandom, 1'b1);
    add_event(40'd5, 16'd10);
    add_event(40'(N_LONG - 1) * 40'd977 + 40'd5, rand_chan());
    add_event(40'(N_LONG / 2) * 40'd977 + 40'd5, rand_chan());
    for (int i = 0; i < 8; i++)
      add_event(40'($urandom_range(0, N_LONG - 1)) * 40'd977 + 40'd5, rand_chan());
    add_op(cyc_pkg::MODE_REPORT);
    add_op(cyc_pkg::MODE_CLEAR);
    add_op(cyc_pkg::MODE_REPORT);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || cfg_psel || yield_q.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && yield_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
